// ===== rtl/lz4d_pkg.sv =====
package lz4d_pkg;

    localparam int WINDOW_DEPTH = 65536;
    localparam int COUNT_BITS   = 24;
    localparam int LEN_BITS     = 24;
    localparam int WIN_BITS     = $clog2(WINDOW_DEPTH);
    localparam int CALC_BITS    = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 2;

    localparam logic [3:0] NIB_EXT       = 4'd15;
    localparam logic [3:0] NIB_MASK      = 4'h0F;
    localparam logic [7:0] EXT_CHAIN     = 8'd255;
    localparam int         MATCH_MIN     = 4;
    localparam int         MATCH_EXT_LEN = 19;
    localparam int         BYTE_BITS     = 8;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        PH_TOKEN    = 3'd0,
        PH_LITEXT   = 3'd1,
        PH_LIT      = 3'd2,
        PH_OFFLO    = 3'd3,
        PH_OFFHI    = 3'd4,
        PH_MATCHEXT = 3'd5,
        PH_MATCH    = 3'd6,
        PH_ENDED    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN    = 3'd0,
        ST_DONE   = 3'd1,
        ST_TRUNC  = 3'd2,
        ST_BADOFF = 3'd3,
        ST_OVER   = 3'd4,
        ST_SHORT  = 3'd5,
        ST_MISUSE = 3'd6
    } status_t;

    typedef struct packed {
        logic                emit;
        logic                copy;
        logic [7:0]          lit_byte;
        logic [WIN_BITS-1:0] rd_addr;
        logic [WIN_BITS-1:0] wr_addr;
        status_t             status;
        logic                block_end;
        logic                match_pending;
    } step_t;

endpackage

// ===== rtl/lz4d_ram.sv =====
module lz4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lz4d_parse.sv =====
module lz4d_parse
    import lz4d_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [1:0]          cmd,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic [LEN_BITS-1:0] out_length,
    output step_t               step
);

    localparam logic [CALC_BITS-1:0] CNT_MAX   = CALC_BITS'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [CALC_BITS-1:0] WIN_LIMIT = CALC_BITS'(WINDOW_DEPTH);

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] lit_rem_reg, lit_rem_next;
    logic [COUNT_BITS-1:0] match_rem_reg, match_rem_next;
    logic [3:0]            nibble_reg, nibble_next;
    logic [15:0]           offset_reg, offset_next;
    logic [COUNT_BITS-1:0] produced_reg, produced_next;
    logic                  src_end_reg, src_end_next;

    logic [CALC_BITS-1:0]  len_w, limit_w, prod_w, prod_inc_w;
    logic [COUNT_BITS-1:0] prod_inc;
    logic [COUNT_BITS-1:0] match_rem_dec;
    logic [CALC_BITS-1:0]  lit_sum, match_sum, tok_match;
    logic [3:0]            tok_hi;
    logic [15:0]           new_off;
    logic                  lit_sum_over, match_sum_over, tok_over, tok_match_over;
    logic                  prod_ge, prod_inc_ge, bad_off, misuse;
    cmd_t                  cmd_c;

    assign cmd_c      = cmd_t'(cmd);
    assign len_w      = CALC_BITS'(out_length);
    assign limit_w    = (len_w > CNT_MAX) ? CNT_MAX : len_w;
    assign prod_w     = CALC_BITS'(produced_reg);
    assign prod_inc   = produced_reg + COUNT_BITS'(1);
    assign prod_inc_w = CALC_BITS'(prod_inc);
    assign prod_ge    = prod_w >= limit_w;
    assign prod_inc_ge = prod_inc_w >= limit_w;
    assign match_rem_dec = match_rem_reg - COUNT_BITS'(1);

    assign tok_hi    = in_byte[7:4];
    assign tok_over  = (prod_w + CALC_BITS'(tok_hi)) > limit_w;
    assign lit_sum   = CALC_BITS'(lit_rem_reg) + CALC_BITS'(in_byte);
    assign lit_sum_over = (prod_w + lit_sum) > limit_w;
    assign match_sum = CALC_BITS'(match_rem_reg) + CALC_BITS'(in_byte);
    assign match_sum_over = (prod_w + match_sum) > limit_w;
    assign tok_match = CALC_BITS'(nibble_reg) + CALC_BITS'(MATCH_MIN);
    assign tok_match_over = (prod_w + tok_match) > limit_w;

    assign new_off = {in_byte, offset_reg[7:0]};
    assign bad_off = (new_off == 16'd0) || (CALC_BITS'(new_off) > prod_w) ||
                     (CALC_BITS'(new_off) > WIN_LIMIT);

    assign misuse = (cmd_c != CMD_BYTE && cmd_c != CMD_STEP && cmd_c != CMD_START) ||
                    (phase_reg == PH_ENDED) ||
                    ((cmd_c == CMD_STEP) != (phase_reg == PH_MATCH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TOKEN;
            lit_rem_reg   <= '0;
            match_rem_reg <= '0;
            nibble_reg    <= '0;
            offset_reg    <= '0;
            produced_reg  <= '0;
            src_end_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            lit_rem_reg   <= lit_rem_next;
            match_rem_reg <= match_rem_next;
            nibble_reg    <= nibble_next;
            offset_reg    <= offset_next;
            produced_reg  <= produced_next;
            src_end_reg   <= src_end_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        lit_rem_next   = lit_rem_reg;
        match_rem_next = match_rem_reg;
        nibble_next    = nibble_reg;
        offset_next    = offset_reg;
        produced_next  = produced_reg;
        src_end_next   = src_end_reg;

        step.emit      = 1'b0;
        step.copy      = 1'b0;
        step.lit_byte  = in_byte;
        step.rd_addr   = WIN_BITS'(produced_reg) - WIN_BITS'(offset_reg);
        step.wr_addr   = WIN_BITS'(produced_reg);
        step.status    = ST_RUN;
        step.block_end = 1'b0;

        if (cmd_c == CMD_START) begin
            phase_next     = PH_TOKEN;
            lit_rem_next   = '0;
            match_rem_next = '0;
            nibble_next    = '0;
            offset_next    = '0;
            produced_next  = '0;
            src_end_next   = 1'b0;
        end else if (misuse) begin
            step.status = ST_MISUSE;
        end else if (cmd_c == CMD_STEP) begin
            step.emit      = 1'b1;
            step.copy      = 1'b1;
            produced_next  = prod_inc;
            match_rem_next = match_rem_dec;
            if (match_rem_dec == '0) begin
                if (prod_inc_ge) begin
                    phase_next = PH_ENDED; step.status = ST_DONE; step.block_end = 1'b1;
                end else if (src_end_reg) begin
                    phase_next = PH_ENDED; step.status = ST_SHORT; step.block_end = 1'b1;
                end else begin
                    phase_next = PH_TOKEN;
                end
            end
        end else begin
            case (phase_reg)
                PH_TOKEN: begin
                    if (prod_ge) begin
                        phase_next = PH_ENDED; step.status = ST_DONE; step.block_end = 1'b1;
                    end else begin
                        lit_rem_next = COUNT_BITS'(tok_hi);
                        nibble_next  = in_byte[3:0] & NIB_MASK;
                        if (tok_hi == NIB_EXT && !in_last) begin
                            phase_next = PH_LITEXT;
                        end else if (tok_over) begin
                            phase_next = PH_ENDED; step.status = ST_OVER; step.block_end = 1'b1;
                        end else if (in_last) begin
                            phase_next = PH_ENDED; step.status = ST_TRUNC; step.block_end = 1'b1;
                        end else begin
                            phase_next = (tok_hi != 4'd0) ? PH_LIT : PH_OFFLO;
                        end
                    end
                end
                PH_LITEXT: begin
                    if (lit_sum_over) begin
                        phase_next = PH_ENDED; step.status = ST_OVER; step.block_end = 1'b1;
                    end else begin
                        lit_rem_next = COUNT_BITS'(lit_sum);
                        if (in_last) begin
                            phase_next = PH_ENDED; step.status = ST_TRUNC; step.block_end = 1'b1;
                        end else if (in_byte != EXT_CHAIN) begin
                            phase_next = (lit_sum != '0) ? PH_LIT : PH_OFFLO;
                        end
                    end
                end
                PH_LIT: begin
                    step.emit     = 1'b1;
                    produced_next = prod_inc;
                    lit_rem_next  = lit_rem_reg - COUNT_BITS'(1);
                    if (prod_inc_ge) begin
                        phase_next = PH_ENDED; step.status = ST_DONE; step.block_end = 1'b1;
                    end else if (in_last) begin
                        phase_next = PH_ENDED; step.status = ST_TRUNC; step.block_end = 1'b1;
                    end else if (lit_rem_next == '0) begin
                        phase_next = PH_OFFLO;
                    end
                end
                PH_OFFLO: begin
                    offset_next = {8'd0, in_byte};
                    if (in_last) begin
                        phase_next = PH_ENDED; step.status = ST_TRUNC; step.block_end = 1'b1;
                    end else begin
                        phase_next = PH_OFFHI;
                    end
                end
                PH_OFFHI: begin
                    offset_next = new_off;
                    if (bad_off) begin
                        phase_next = PH_ENDED; step.status = ST_BADOFF; step.block_end = 1'b1;
                    end else begin
                        match_rem_next = COUNT_BITS'(tok_match);
                        if (tok_match == CALC_BITS'(MATCH_EXT_LEN) && !in_last) begin
                            phase_next = PH_MATCHEXT;
                        end else if (tok_match_over) begin
                            phase_next = PH_ENDED; step.status = ST_OVER; step.block_end = 1'b1;
                        end else begin
                            phase_next   = PH_MATCH;
                            src_end_next = in_last;
                        end
                    end
                end
                PH_MATCHEXT: begin
                    if (match_sum_over) begin
                        phase_next = PH_ENDED; step.status = ST_OVER; step.block_end = 1'b1;
                    end else begin
                        match_rem_next = COUNT_BITS'(match_sum);
                        if (in_byte != EXT_CHAIN || in_last) begin
                            phase_next   = PH_MATCH;
                            src_end_next = in_last;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        step.match_pending = (phase_next == PH_MATCH);
    end

endmodule

// ===== rtl/lz4_block_decoder.sv =====
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    tuser cmd, tdata in_byte, tlast in_last
// m_        out        m_tvalid / m_tready    tdata out_byte,status,match_pending,
//                                             tuser byte_valid, tlast block_end
// cfg_      in         cfg_valid / cfg_ready  out_length
//
// One result item per input item; one a cycle unless m_ stalls; registered in s1, then m_.
// The history read for a match step returns in the cycle after acceptance; the previous item's
// write is forwarded when both hit the same entry.
// Synchronous active-low reset clears the parser and handshake state; history is not cleared.
// A stalled m_ channel holds the result and the item behind it, then drops s_tready.
module lz4_block_decoder
    import lz4d_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] in_byte
    input  logic [1:0]          s_tuser,   // [1:0] cmd
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [7:0] out_byte, [10:8] status, [11] match_pending
    output logic                m_tuser,   // [0] byte_valid
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_BITS-1:0] cfg_data
);

    logic [LEN_BITS-1:0] out_length_reg;
    step_t               step;
    logic                accept, out_free, s1_move, fwd_hit;
    logic [7:0]          ram_rdata, s1_byte, s1_out_byte;

    logic                s1_valid_reg;
    step_t               s1_step_reg;
    logic                s1_fwd_reg;
    logic [7:0]          s1_fwd_byte_reg;

    logic                m_valid_reg;
    logic [7:0]          m_byte_reg;
    status_t             m_status_reg;
    logic                m_pend_reg, m_bv_reg, m_end_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;
    assign s1_move   = s1_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_length_reg <= '0;
        end else if (cfg_valid) begin
            out_length_reg <= cfg_data;
        end
    end

    lz4d_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cmd        (s_tuser),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .out_length (out_length_reg),
        .step       (step)
    );

    assign s1_byte     = s1_step_reg.copy ? (s1_fwd_reg ? s1_fwd_byte_reg : ram_rdata)
                                          : s1_step_reg.lit_byte;
    assign s1_out_byte = s1_step_reg.emit ? s1_byte : 8'd0;
    assign fwd_hit     = s1_move && s1_step_reg.emit && (s1_step_reg.wr_addr == step.rd_addr);

    lz4d_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (s1_move && s1_step_reg.emit),
        .wr_addr (s1_step_reg.wr_addr),
        .wr_data (s1_byte),
        .rd_en   (accept && step.copy),
        .rd_addr (step.rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_step_reg     <= step;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_byte_reg <= s1_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_byte_reg   <= s1_out_byte;
            m_status_reg <= s1_step_reg.status;
            m_pend_reg   <= s1_step_reg.match_pending;
            m_bv_reg     <= s1_step_reg.emit;
            m_end_reg    <= s1_step_reg.block_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_pend_reg, m_status_reg, m_byte_reg};
    assign m_tuser  = m_bv_reg;
    assign m_tlast  = m_end_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import lz4d_pkg::*;

    localparam logic [1:0]          CMD_BAD    = 2'd3;
    localparam logic [LEN_BITS-1:0] LEN_MAX    = {LEN_BITS{1'b1}};
    localparam int unsigned         OPEN_ROOM  = 400;
    localparam int unsigned         RAND_ITEMS = 1050;
    localparam int unsigned         SETTLE     = 8;
    localparam int unsigned         LIMIT      = 400000;
    localparam int unsigned         IDLE_PCT   = 37;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct {
        logic [7:0] data;
        logic       valid;
        status_t    status;
        logic       fin;
        logic       pending;
    } dec_out_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LEN_BITS-1:0] cfg_data  = '0;

    in_item_t    pending_in[$];
    dec_out_t    decoded_due[$];
    bit          in_taken  = 1'b0;
    bit          cfg_taken = 1'b0;
    int unsigned idle_pct  = IDLE_PCT;
    int unsigned err_count = 0;
    int unsigned n_results = 0;
    int unsigned cycles    = 0;
    int unsigned rand_count = 0;

    // decoder state as the block should hold it
    logic [LEN_BITS-1:0]   length_reg = '0;
    phase_t                dec_phase  = PH_TOKEN;
    logic [LEN_BITS-1:0]   lit_left   = '0;
    logic [LEN_BITS-1:0]   match_left = '0;
    logic [3:0]            match_nib  = '0;
    logic [15:0]           match_off  = '0;
    logic [COUNT_BITS-1:0] out_count  = '0;
    logic                  src_done   = 1'b0;
    logic [7:0]            window [WINDOW_DEPTH];

    lz4_block_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned umin(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic void end_block(status_t code, inout dec_out_t r);
        dec_phase = PH_ENDED;
        r.status  = code;
        r.fin     = 1'b1;
    endfunction

    function automatic void put_byte(logic [7:0] v, inout dec_out_t r);
        window[out_count[WIN_BITS-1:0]] = v;
        out_count = out_count + 1'b1;
        r.data    = v;
        r.valid   = 1'b1;
    endfunction

    function automatic bit over_room(logic [CALC_BITS-1:0] len);
        return (CALC_BITS'(out_count) + len) > CALC_BITS'(length_reg);
    endfunction

    function automatic void literals_known(logic last, inout dec_out_t r);
        if (over_room(CALC_BITS'(lit_left))) begin
            end_block(ST_OVER, r);
            return;
        end
        dec_phase = (lit_left != 0) ? PH_LIT : PH_OFFLO;
        if (last) begin
            end_block(ST_TRUNC, r);
        end
    endfunction

    function automatic void match_known(logic last, inout dec_out_t r);
        if (over_room(CALC_BITS'(match_left))) begin
            end_block(ST_OVER, r);
            return;
        end
        dec_phase = PH_MATCH;
        src_done  = last;
    endfunction

    function automatic dec_out_t decode_step(logic [1:0] cmd, logic [7:0] b, logic last);
        dec_out_t             r;
        logic [CALC_BITS-1:0] sum;
        logic [WIN_BITS-1:0]  src;
        r = '{data: '0, valid: 1'b0, status: ST_RUN, fin: 1'b0, pending: 1'b0};
        if (cmd == CMD_START) begin
            dec_phase  = PH_TOKEN;
            lit_left   = '0;
            match_left = '0;
            match_nib  = '0;
            match_off  = '0;
            out_count  = '0;
            src_done   = 1'b0;
        end else if (cmd == CMD_BAD || dec_phase == PH_ENDED ||
                     ((cmd == CMD_STEP) != (dec_phase == PH_MATCH))) begin
            r.status = ST_MISUSE;
        end else if (cmd == CMD_STEP) begin
            src = out_count[WIN_BITS-1:0] - match_off;
            put_byte(window[src], r);
            match_left = match_left - 1'b1;
            if (match_left == 0) begin
                if (out_count >= length_reg) begin
                    end_block(ST_DONE, r);
                end else if (src_done) begin
                    end_block(ST_SHORT, r);
                end else begin
                    dec_phase = PH_TOKEN;
                end
            end
        end else begin
            case (dec_phase)
                PH_TOKEN: begin
                    if (out_count >= length_reg) begin
                        end_block(ST_DONE, r);
                    end else begin
                        lit_left  = LEN_BITS'(b[7:4]);
                        match_nib = b[3:0];
                        if (b[7:4] == NIB_EXT && !last) begin
                            dec_phase = PH_LITEXT;
                        end else begin
                            literals_known(last, r);
                        end
                    end
                end
                PH_LITEXT: begin
                    sum = CALC_BITS'(lit_left) + CALC_BITS'(b);
                    if (over_room(sum)) begin
                        end_block(ST_OVER, r);
                    end else begin
                        lit_left = LEN_BITS'(sum);
                        if (b != EXT_CHAIN || last) begin
                            literals_known(last, r);
                        end
                    end
                end
                PH_LIT: begin
                    put_byte(b, r);
                    lit_left = lit_left - 1'b1;
                    if (out_count >= length_reg) begin
                        end_block(ST_DONE, r);
                    end else begin
                        if (lit_left == 0) begin
                            dec_phase = PH_OFFLO;
                        end
                        if (last) begin
                            end_block(ST_TRUNC, r);
                        end
                    end
                end
                PH_OFFLO: begin
                    match_off = {8'h00, b};
                    dec_phase = PH_OFFHI;
                    if (last) begin
                        end_block(ST_TRUNC, r);
                    end
                end
                PH_OFFHI: begin
                    match_off[15:8] = b;
                    if (match_off == 0 || COUNT_BITS'(match_off) > out_count ||
                        int'(match_off) > WINDOW_DEPTH) begin
                        end_block(ST_BADOFF, r);
                    end else begin
                        match_left = LEN_BITS'(match_nib) + LEN_BITS'(MATCH_MIN);
                        if (match_left == LEN_BITS'(MATCH_EXT_LEN) && !last) begin
                            dec_phase = PH_MATCHEXT;
                        end else begin
                            match_known(last, r);
                        end
                    end
                end
                default: begin
                    sum = CALC_BITS'(match_left) + CALC_BITS'(b);
                    if (over_room(sum)) begin
                        end_block(ST_OVER, r);
                    end else begin
                        match_left = LEN_BITS'(sum);
                        if (b != EXT_CHAIN || last) begin
                            match_known(last, r);
                        end
                    end
                end
            endcase
        end
        r.pending = (dec_phase == PH_MATCH);
        return r;
    endfunction

    task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
        err_count++;
        if (err_count <= 100) begin
            $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                     n_results, field, got, want);
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge aclk) begin
        in_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_in.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_in.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        dec_out_t w;
        if (aresetn && s_tvalid && s_tready) begin
            decoded_due.push_back(decode_step(s_tuser, s_tdata, s_tlast));
            in_taken = 1'b1;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            length_reg = cfg_data;
            cfg_taken  = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (decoded_due.size() == 0) begin
                flag_mismatch("unexpected item", m_tdata, 0);
            end else begin
                w = decoded_due.pop_front();
                if (m_tdata[7:0] !== w.data)
                    flag_mismatch("out_byte", m_tdata[7:0], w.data);
                if (m_tuser !== w.valid)
                    flag_mismatch("byte_valid", m_tuser, w.valid);
                if (m_tdata[10:8] !== w.status)
                    flag_mismatch("status", m_tdata[10:8], w.status);
                if (m_tlast !== w.fin)
                    flag_mismatch("block_end", m_tlast, w.fin);
                if (m_tdata[11] !== w.pending)
                    flag_mismatch("match_pending", m_tdata[11], w.pending);
            end
        end
    end

    function automatic in_item_t mk_item(logic [1:0] c, logic [7:0] d, logic l);
        return '{cmd: c, data: d, last: l};
    endfunction

    function automatic void queue_item(logic [1:0] c, logic [7:0] d, logic l);
        pending_in.push_back(mk_item(c, d, l));
    endfunction

    task automatic set_length(logic [LEN_BITS-1:0] v);
        @(negedge aclk);
        cfg_taken = 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
        cfg_data  <= LEN_BITS'($urandom);
    endtask

    task automatic drain_results();
        do @(posedge aclk);
        while (pending_in.size() != 0 || s_tvalid || decoded_due.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic add_block(int unsigned len_cfg);
        in_item_t    blk[$];
        int unsigned made, room, lit, mlen, off, rem, nseq, seqs, pos, sel;
        int          last_idx;
        bit          open_ended, closing;
        open_ended = (len_cfg == LEN_MAX);
        nseq       = $urandom_range(1, 4);
        made       = 0;
        seqs       = 0;
        closing    = 1'b0;
        blk.push_back(mk_item(CMD_START, 8'($urandom), 1'($urandom)));
        if (len_cfg == 0) begin
            blk.push_back(mk_item(CMD_BYTE, 8'($urandom), 1'($urandom)));
            closing = 1'b1;
        end
        while (!closing) begin
            room = open_ended ? OPEN_ROOM : len_cfg - made;
            lit  = ($urandom_range(9) == 0) ? $urandom_range(room)
                                            : $urandom_range(umin(room, 18));
            if (made == 0 && lit == 0)
                lit = 1;
            if (room - lit < MATCH_MIN)
                lit = room;
            seqs++;
            mlen = 0;
            if (lit != room) begin
                mlen = ($urandom_range(9) == 0)
                     ? $urandom_range(MATCH_MIN, room - lit)
                     : $urandom_range(MATCH_MIN, umin(room - lit, 22));
            end
            closing = (mlen == 0) ||
                      (open_ended ? (seqs >= nseq) : (made + lit + mlen == len_cfg));
            blk.push_back(mk_item(CMD_BYTE,
                {4'(umin(lit, 15)),
                 (mlen == 0) ? 4'($urandom) : 4'(umin(mlen - MATCH_MIN, 15))}, 1'b0));
            if (lit >= 15) begin
                rem = lit - 15;
                while (rem >= 255) begin
                    blk.push_back(mk_item(CMD_BYTE, EXT_CHAIN, 1'b0));
                    rem -= 255;
                end
                blk.push_back(mk_item(CMD_BYTE, 8'(rem), 1'b0));
            end
            repeat (lit) blk.push_back(mk_item(CMD_BYTE, 8'($urandom), 1'b0));
            last_idx = blk.size() - 1;
            if (mlen != 0) begin
                off = $urandom_range(1) ? $urandom_range(1, umin(made + lit, 8))
                                        : $urandom_range(1, umin(made + lit, 65535));
                blk.push_back(mk_item(CMD_BYTE, off[7:0], 1'b0));
                blk.push_back(mk_item(CMD_BYTE, off[15:8], 1'b0));
                if (mlen >= MATCH_EXT_LEN) begin
                    rem = mlen - MATCH_EXT_LEN;
                    while (rem >= 255) begin
                        blk.push_back(mk_item(CMD_BYTE, EXT_CHAIN, 1'b0));
                        rem -= 255;
                    end
                    blk.push_back(mk_item(CMD_BYTE, 8'(rem), 1'b0));
                end
                last_idx = blk.size() - 1;
                repeat (mlen) blk.push_back(mk_item(CMD_STEP, 8'($urandom), 1'($urandom)));
            end
            if (closing)
                blk[last_idx].last = 1'b1;
            made += lit + mlen;
        end
        // break a share of the blocks
        sel = $urandom_range(99);
        pos = $urandom_range(1, blk.size() - 1);
        if (sel < 8) begin
            blk[pos].last = 1'b1;
        end else if (sel < 14) begin
            blk[pos].data = 8'($urandom);
        end else if (sel < 20) begin
            blk.insert(pos, mk_item(2'($urandom), 8'($urandom), 1'($urandom)));
        end else if (sel < 25) begin
            blk.delete(pos);
        end else if (sel < 30) begin
            while (blk.size() > pos) void'(blk.pop_back());
        end
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 2))
                blk.push_back(mk_item(2'($urandom), 8'($urandom), 1'($urandom)));
        end
        foreach (blk[i]) pending_in.push_back(blk[i]);
        rand_count += blk.size();
    endtask

    initial begin
        int unsigned         phase_no;
        logic [LEN_BITS-1:0] len_now;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        set_length('0);
        queue_item(CMD_START, 8'hFF, 1'b1);
        queue_item(CMD_BYTE, 8'hFF, 1'b0);
        queue_item(CMD_BYTE, 8'h00, 1'b1);
        queue_item(CMD_BAD, 8'h00, 1'b0);
        drain_results();

        set_length(LEN_BITS'(7));
        queue_item(CMD_START, 8'h00, 1'b0);
        queue_item(CMD_STEP, 8'h00, 1'b0);
        queue_item(CMD_BYTE, 8'hF0, 1'b0);
        queue_item(CMD_BYTE, 8'h00, 1'b0);
        queue_item(CMD_START, 8'h00, 1'b0);
        queue_item(CMD_BYTE, 8'h21, 1'b0);
        queue_item(CMD_BYTE, 8'h00, 1'b0);
        queue_item(CMD_BYTE, 8'hFF, 1'b0);
        queue_item(CMD_BYTE, 8'h02, 1'b0);
        queue_item(CMD_BYTE, 8'h00, 1'b0);
        queue_item(CMD_BYTE, 8'h5A, 1'b0);
        repeat (5) queue_item(CMD_STEP, 8'hFF, 1'b1);
        queue_item(CMD_START, 8'h00, 1'b0);
        queue_item(CMD_BYTE, 8'h10, 1'b0);
        queue_item(CMD_BYTE, 8'h12, 1'b0);
        queue_item(CMD_BYTE, 8'h05, 1'b0);
        queue_item(CMD_BYTE, 8'h00, 1'b0);
        drain_results();

        set_length(LEN_MAX);
        queue_item(CMD_START, 8'h00, 1'b0);
        queue_item(CMD_BYTE, 8'hF0, 1'b0);
        queue_item(CMD_BYTE, 8'hFF, 1'b0);
        queue_item(CMD_BYTE, 8'h01, 1'b1);
        queue_item(CMD_START, 8'h00, 1'b0);
        queue_item(CMD_BYTE, 8'h10, 1'b0);
        queue_item(CMD_BYTE, 8'h33, 1'b0);
        queue_item(CMD_BYTE, 8'h01, 1'b0);
        queue_item(CMD_BYTE, 8'h00, 1'b1);
        repeat (4) queue_item(CMD_STEP, 8'h00, 1'b0);
        drain_results();

        phase_no = 0;
        while (rand_count < RAND_ITEMS) begin
            case ($urandom_range(7))
                0:       len_now = '0;
                1:       len_now = LEN_MAX;
                2:       len_now = LEN_BITS'($urandom_range(200, 400));
                default: len_now = LEN_BITS'($urandom_range(1, 48));
            endcase
            idle_pct = (phase_no == 3) ? 0 : IDLE_PCT;
            set_length(len_now);
            repeat ($urandom_range(2, 3)) add_block(len_now);
            drain_results();
            phase_no++;
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
